// ===== src/dqe_pkg.sv =====
package dqe_pkg;

  localparam logic [5:0] MAX_LABEL = 6'd63;
  localparam logic [8:0] MAX_NAME  = 9'd255;
  localparam logic [7:0] DOT_CHAR  = 8'h2E;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_LABEL = 2'd1;
  localparam logic [1:0] ERR_NAME  = 2'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Write record of one character: up to three byte writes, all with one error code.
  typedef struct packed {
    logic       ch_valid;
    logic [8:0] ch_addr;
    logic [7:0] ch_byte;
    logic       len_valid;
    logic [8:0] len_addr;
    logic [5:0] len_byte;
    logic       term_valid;
    logic [8:0] term_addr;
    logic [1:0] err;
  } rec_t;

  typedef struct packed {
    logic push;
    rec_t data;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
    rec_t head;
  } fifo_stat_t;

endpackage

// ===== src/dns_qname_label_encoder_core.sv =====
// A byte write is held in a record queue entry, then in the output register.
// Throughput: one character per cycle unless stalled; a final character makes up to three write beats,
//   one per cycle from the output register while out_stall is low, absorbed by a 4-entry record queue.
// Input stall rises only while that queue is full.
// Reset (rst, synchronous, active high) clears label state, queue pointers and out_valid.
module dns_qname_label_encoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] name_char,
  input  logic       is_final,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] write_addr,
  output logic [7:0] write_byte,
  output logic       name_done,
  output logic [8:0] encoded_size,
  output logic [1:0] name_error
);
  import dqe_pkg::*;

  push_t      push_bus;
  fifo_stat_t stat;
  logic       pop;

  // Front: accept characters, track label and name counters, build one write record each beat.
  dqe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .name_char (name_char),
    .is_final  (is_final),
    .full      (stat.full),
    .in_stall  (in_stall),
    .push_out  (push_bus)
  );

  // Queue: decouple the per-character front from the per-write back end.
  dqe_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push_in (push_bus),
    .pop     (pop),
    .stat    (stat)
  );

  // Back: split each record into its write beats and hold them in the output register.
  dqe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .stat         (stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .write_addr   (write_addr),
    .write_byte   (write_byte),
    .name_done    (name_done),
    .encoded_size (encoded_size),
    .name_error   (name_error)
  );

endmodule

// ===== src/dqe_front.sv =====
module dqe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        name_char,
  input  logic              is_final,
  input  logic              full,
  output logic              in_stall,
  output dqe_pkg::push_t    push_out
);
  import dqe_pkg::*;

  logic [8:0] label_start;
  logic [5:0] label_count;
  logic [8:0] name_length;
  logic [1:0] error_code;

  logic [8:0] label_start_next;
  logic [5:0] label_count_next;
  logic [8:0] name_length_next;
  logic [1:0] error_code_next;

  logic       take;
  logic       accepted;
  logic       is_dot;
  logic       ch_emit;
  logic       len_emit;
  logic [1:0] err1;
  logic [1:0] err2;
  logic [5:0] ll1;
  logic [8:0] ls1;
  rec_t       rec;

  assign in_stall = full;
  assign take     = in_valid && !full;

  always_comb begin
    accepted = name_length < MAX_NAME;
    is_dot   = name_char == DOT_CHAR;
    err1     = accepted ? error_code : ERR_NAME;
    ch_emit  = accepted && !is_dot && (label_count < MAX_LABEL);
    if (accepted && !is_dot && !(label_count < MAX_LABEL) && err1 == ERR_NONE) begin
      err2 = ERR_LABEL;
    end else begin
      err2 = err1;
    end
    ll1      = label_count + {5'd0, ch_emit};
    len_emit = ((accepted && is_dot) || is_final) && (ll1 != 6'd0);
    ls1      = len_emit ? (label_start + {3'd0, ll1} + 9'd1) : label_start;

    rec.ch_valid   = ch_emit;
    rec.ch_addr    = label_start + 9'd1 + {3'd0, label_count};
    rec.ch_byte    = name_char;
    rec.len_valid  = len_emit;
    rec.len_addr   = label_start;
    rec.len_byte   = ll1;
    rec.term_valid = is_final;
    rec.term_addr  = ls1;
    rec.err        = err2;

    if (is_final) begin
      label_start_next = 9'd0;
      label_count_next = 6'd0;
      name_length_next = 9'd0;
      error_code_next  = ERR_NONE;
    end else begin
      label_start_next = ls1;
      label_count_next = len_emit ? 6'd0 : ll1;
      name_length_next = accepted ? (name_length + 9'd1) : name_length;
      error_code_next  = err2;
    end
  end

  // Drop records that carry no write.
  assign push_out.push = take && (rec.ch_valid || rec.len_valid || rec.term_valid);
  assign push_out.data = rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      label_start <= 9'd0;
      label_count <= 6'd0;
      name_length <= 9'd0;
      error_code  <= ERR_NONE;
    end else if (take) begin
      label_start <= label_start_next;
      label_count <= label_count_next;
      name_length <= name_length_next;
      error_code  <= error_code_next;
    end
  end

endmodule

// ===== src/dqe_fifo.sv =====
module dqe_fifo (
  input  logic                clk,
  input  logic                rst,
  input  dqe_pkg::push_t      push_in,
  input  logic                pop,
  output dqe_pkg::fifo_stat_t stat
);
  import dqe_pkg::*;

  rec_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_pop;

  assign stat.full  = count == (FIFO_AW+1)'(FIFO_DEPTH);
  assign stat.empty = count == '0;
  assign stat.head  = entries[rd_ptr];
  assign do_pop     = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (push_in.push) begin
      entries[wr_ptr] <= push_in.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_in.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (FIFO_AW+1)'(push_in.push) - (FIFO_AW+1)'(do_pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) push_in.push |-> !stat.full)
    else $error("dqe_fifo: push while full");
  assert property (@(posedge clk) disable iff (rst) pop |-> !stat.empty)
    else $error("dqe_fifo: pop while empty");
  assert property (@(posedge clk) disable iff (rst) count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("dqe_fifo: count past depth");

endmodule

// ===== src/dqe_back.sv =====
module dqe_back (
  input  logic                clk,
  input  logic                rst,
  input  dqe_pkg::fifo_stat_t stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [8:0]          write_addr,
  output logic [7:0]          write_byte,
  output logic                name_done,
  output logic [8:0]          encoded_size,
  output logic [1:0]          name_error
);
  import dqe_pkg::*;

  logic [2:0] sent;
  logic [2:0] rem;
  logic [2:0] sel;
  logic       load;
  logic       last;
  rec_t       h;

  assign h    = stat.head;
  assign load = !out_valid || !out_stall;
  assign rem  = {h.term_valid, h.len_valid, h.ch_valid} & ~sent;

  always_comb begin
    sel  = {rem[2] && !rem[1] && !rem[0], rem[1] && !rem[0], rem[0]};
    last = (rem & ~sel) == 3'd0;
  end

  assign pop = !stat.empty && load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sent      <= 3'd0;
    end else if (load) begin
      out_valid <= !stat.empty;
      if (!stat.empty) begin
        sent <= last ? 3'd0 : (sent | sel);
      end
    end
  end

  // Payload: character write, then length byte, then terminator.
  always_ff @(posedge clk) begin
    if (load && !stat.empty) begin
      name_error <= h.err;
      if (sel[0]) begin
        write_addr   <= h.ch_addr;
        write_byte   <= h.ch_byte;
        name_done    <= 1'b0;
        encoded_size <= 9'd0;
      end else if (sel[1]) begin
        write_addr   <= h.len_addr;
        write_byte   <= {2'd0, h.len_byte};
        name_done    <= 1'b0;
        encoded_size <= 9'd0;
      end else begin
        write_addr   <= h.term_addr;
        write_byte   <= 8'd0;
        name_done    <= 1'b1;
        encoded_size <= h.term_addr + 9'd1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && name_done) |->
      (write_byte == 8'd0 && encoded_size == write_addr + 9'd1))
    else $error("dqe_back: terminator beat malformed");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !name_done) |-> encoded_size == 9'd0)
    else $error("dqe_back: size on non-terminator beat");
  assert property (@(posedge clk) disable iff (rst) stat.empty |-> sent == 3'd0)
    else $error("dqe_back: stale progress with empty queue");

endmodule
